// ===== hw/rtl/sample_filter_bank_defines.svh =====
// assertion macros used by the filter bank checker
// needs clk and rst_n in the scope where a macro is used
`ifndef SAMPLE_FILTER_BANK_DEFINES_SVH
`define SAMPLE_FILTER_BANK_DEFINES_SVH

// same-cycle implication, off while in reset
`define SFB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sample_filter_bank check failed");

// next-cycle implication, off while in reset
`define SFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sample_filter_bank check failed");

`endif

// ===== hw/rtl/sfb_pkg.sv =====
// shared types and constants of the sample filter bank
// used by sfb_ctrl, sfb_datapath and the top level
`default_nettype none

package sfb_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int TAP_COUNT = 5;
  localparam int REG_COUNT = 7;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 3 * SAMPLE_W;

  typedef logic [GAIN_W-1:0]    gain_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [2:0]           tap_idx_t;
  typedef logic [2:0]           mul_sel_t;

  // register indexes
  localparam cfg_idx_t REG_TAP0  = 3'd0;
  localparam cfg_idx_t REG_TAP1  = 3'd1;
  localparam cfg_idx_t REG_TAP2  = 3'd2;
  localparam cfg_idx_t REG_TAP3  = 3'd3;
  localparam cfg_idx_t REG_TAP4  = 3'd4;
  localparam cfg_idx_t REG_DECAY = 3'd5;
  localparam cfg_idx_t REG_INPUT = 3'd6;

  localparam gain_t REG_RESET [REG_COUNT] = '{
    16'd1317, 16'd15132, 16'd32643, 16'd15132, 16'd1317, 16'd62259, 16'd3277
  };

  // what the shared multiplier works on in a cycle
  localparam mul_sel_t MUL_NONE  = 3'd0;
  localparam mul_sel_t MUL_DECAY = 3'd1;
  localparam mul_sel_t MUL_INPUT = 3'd2;
  localparam mul_sel_t MUL_MEAN  = 3'd3;
  localparam mul_sel_t MUL_TAP   = 3'd4;

  typedef struct packed {
    logic     load_x;
    logic     win_write;
    logic     clear_acc;
    mul_sel_t mul_sel;
    tap_idx_t tap_idx;
    logic     iir_upd;
    logic     load_out;
  } sfb_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfb_ctrl.sv =====
// sequencer of the sample filter bank: steps one word through the shared multiplier
// depends on sfb_pkg for command type and multiplier select codes
`default_nettype none

module sfb_ctrl #(
  parameter int WINDOW_LEN = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output sfb_pkg::sfb_cmd_t     cmd
);

  localparam int TAPS = (WINDOW_LEN < sfb_pkg::TAP_COUNT) ? WINDOW_LEN : sfb_pkg::TAP_COUNT;
  localparam sfb_pkg::tap_idx_t LAST_TAP = sfb_pkg::tap_idx_t'(TAPS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_OLD   = 3'd1;
  localparam logic [2:0] ST_INPUT = 3'd2;
  localparam logic [2:0] ST_MEAN  = 3'd3;
  localparam logic [2:0] ST_TAP   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  sfb_pkg::tap_idx_t tap_r, tap_nxt;
  logic              valid_r, valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    tap_nxt   = tap_r;
    valid_nxt = valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_x = 1'b1;
          state_nxt  = ST_OLD;
        end
      end
      ST_OLD: begin
        // tap index 0 points the read port at the slot being replaced
        cmd.win_write = 1'b1;
        cmd.clear_acc = 1'b1;
        cmd.mul_sel   = sfb_pkg::MUL_DECAY;
        state_nxt     = ST_INPUT;
      end
      ST_INPUT: begin
        cmd.mul_sel = sfb_pkg::MUL_INPUT;
        state_nxt   = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.mul_sel = sfb_pkg::MUL_MEAN;
        tap_nxt     = '0;
        state_nxt   = ST_TAP;
      end
      ST_TAP: begin
        cmd.mul_sel = sfb_pkg::MUL_TAP;
        cmd.tap_idx = tap_r;
        // iir sum is complete by the first tap cycle
        cmd.iir_upd = (tap_r == '0);
        if (tap_r == LAST_TAP) begin
          state_nxt = ST_OUT;
        end else begin
          tap_nxt = tap_r + 3'd1;
        end
      end
      ST_OUT: begin
        if (!valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          valid_nxt    = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfb_datapath.sv =====
// datapath of the sample filter bank: gain registers, sample window, shared
// multiplier, accumulators and result register; depends on sfb_pkg
`default_nettype none

module sfb_datapath #(
  parameter int WINDOW_LEN = 5
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire sfb_pkg::cfg_idx_t               cfg_index,
  input  wire sfb_pkg::gain_t                  cfg_wdata,
  input  wire logic signed [sfb_pkg::SAMPLE_W-1:0] in_sample,
  input  wire sfb_pkg::sfb_cmd_t               cmd,
  output logic signed [sfb_pkg::SAMPLE_W-1:0]  out_mean,
  output logic signed [sfb_pkg::SAMPLE_W-1:0]  out_smoothed,
  output logic signed [sfb_pkg::SAMPLE_W-1:0]  out_fir
);

  localparam int SW        = sfb_pkg::SAMPLE_W;
  localparam int SLOT_W    = $clog2(WINDOW_LEN);
  localparam int SUM_W     = SW + SLOT_W;
  localparam int DIV_SH    = SUM_W + SLOT_W;
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = DIV_SH + 1;
  localparam int P_W       = MUL_A_W + MUL_B_W;
  localparam int TAP_P_W   = SW + sfb_pkg::GAIN_W + 1;
  localparam int FIR_W     = TAP_P_W + 3;
  localparam int IIR_W     = 50;
  localparam int IIR_Q_W   = IIR_W - 16;
  localparam int FIR_Q_W   = FIR_W - 16;
  localparam longint RECIP_L =
    ((longint'(1) << DIV_SH) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);
  localparam logic signed [MUL_B_W-1:0] RECIP = MUL_B_W'(RECIP_L);

  sfb_pkg::gain_t                gain_r [sfb_pkg::REG_COUNT];
  logic signed [SW-1:0]          win_r  [WINDOW_LEN];
  logic [SLOT_W-1:0]             slot_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic signed [31:0]            iir_level_r, iir_level_nxt;
  sfb_pkg::mul_sel_t             prod_sel_r;

  logic signed [SW-1:0]          x_r;
  logic signed [P_W-1:0]         prod_r, prod_nxt;
  logic signed [IIR_W-1:0]       iir_acc_r;
  logic signed [FIR_W-1:0]       fir_acc_r;
  logic signed [SW-1:0]          mean_r, mean_nxt;
  logic signed [SW-1:0]          mean_out_r, smooth_out_r, fir_out_r;

  logic [SLOT_W:0]               tap_ext, slot_ext, rd_wide;
  logic [SLOT_W-1:0]             rd_addr;
  logic signed [SW-1:0]          rd_sample;
  logic [SUM_W-1:0]              mag;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic [SW:0]                   mean_q;
  logic signed [IIR_Q_W-1:0]     iir_q;
  logic signed [FIR_W-1:0]       fir_sum;
  logic signed [FIR_Q_W-1:0]     fir_q;
  logic signed [SW-1:0]          fir_sat, smooth_val;

  // one window read port: slot minus tap index, wrapped
  always_comb begin
    tap_ext  = (SLOT_W+1)'(cmd.tap_idx);
    slot_ext = {1'b0, slot_r};
    if (slot_ext >= tap_ext) begin
      rd_wide = slot_ext - tap_ext;
    end else begin
      rd_wide = slot_ext + (SLOT_W+1)'(WINDOW_LEN) - tap_ext;
    end
    rd_addr   = rd_wide[SLOT_W-1:0];
    rd_sample = win_r[rd_addr];
  end

  // shared multiplier operand selection
  always_comb begin
    mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    case (cmd.mul_sel)
      sfb_pkg::MUL_DECAY: begin
        mul_a = iir_level_r;
        mul_b = MUL_B_W'({1'b0, gain_r[sfb_pkg::REG_DECAY]});
      end
      sfb_pkg::MUL_INPUT: begin
        mul_a = MUL_A_W'(x_r);
        mul_b = MUL_B_W'({1'b0, gain_r[sfb_pkg::REG_INPUT]});
      end
      sfb_pkg::MUL_MEAN: begin
        mul_a = MUL_A_W'(mag);
        mul_b = RECIP;
      end
      sfb_pkg::MUL_TAP: begin
        mul_a = MUL_A_W'(rd_sample);
        mul_b = MUL_B_W'({1'b0, gain_r[cmd.tap_idx]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // mean: reciprocal product gives the quotient magnitude exactly
  always_comb begin
    mean_q   = prod_r[DIV_SH +: SW+1];
    mean_nxt = sum_r[SUM_W-1] ? SW'((SW+1)'(0) - mean_q) : SW'(mean_q);
  end

  // iir level: divide by 2^16 toward zero, clamp to 32 bits
  always_comb begin
    iir_q = IIR_Q_W'(iir_acc_r >>> 16);
    if (iir_acc_r[IIR_W-1] && (iir_acc_r[15:0] != '0)) begin
      iir_q = iir_q + IIR_Q_W'(1);
    end
    if (iir_q > IIR_Q_W'(32'sh7fff_ffff)) begin
      iir_level_nxt = 32'sh7fff_ffff;
    end else if (iir_q < -IIR_Q_W'(33'sh0_8000_0000)) begin
      iir_level_nxt = 32'sh8000_0000;
    end else begin
      iir_level_nxt = iir_q[31:0];
    end
  end

  // results from the finished sums
  always_comb begin
    smooth_val = iir_level_r[31:16];
    if (iir_level_r[31] && (iir_level_r[15:0] != '0)) begin
      smooth_val = smooth_val + 16'sd1;
    end
    // last tap product may still be in flight on the first output cycle
    fir_sum = fir_acc_r;
    if (prod_sel_r == sfb_pkg::MUL_TAP) begin
      fir_sum = fir_acc_r + FIR_W'($signed(prod_r[TAP_P_W-1:0]));
    end
    fir_q = FIR_Q_W'(fir_sum >>> 16);
    if (fir_sum[FIR_W-1] && (fir_sum[15:0] != '0)) begin
      fir_q = fir_q + FIR_Q_W'(1);
    end
    if (fir_q > FIR_Q_W'(32767)) begin
      fir_sat = 16'sh7fff;
    end else if (fir_q < FIR_Q_W'(-32768)) begin
      fir_sat = 16'sh8000;
    end else begin
      fir_sat = fir_q[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= sfb_pkg::REG_RESET;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
      slot_r      <= '0;
      sum_r       <= '0;
      iir_level_r <= '0;
      prod_sel_r  <= sfb_pkg::MUL_NONE;
    end else begin
      if (cfg_wr_en && (cfg_index inside {[sfb_pkg::REG_TAP0:sfb_pkg::REG_INPUT]})) begin
        gain_r[cfg_index] <= cfg_wdata;
      end
      if (cmd.win_write) begin
        // running sum: drop the replaced sample, add the new one
        win_r[slot_r] <= x_r;
        sum_r         <= sum_r - SUM_W'(rd_sample) + SUM_W'(x_r);
      end
      if (cmd.iir_upd) begin
        iir_level_r <= iir_level_nxt;
      end
      if (cmd.load_out) begin
        slot_r <= (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + SLOT_W'(1);
      end
      prod_sel_r <= cmd.mul_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x_r <= in_sample;
    end
    prod_r <= prod_nxt;
    if (cmd.clear_acc) begin
      fir_acc_r <= '0;
    end else if (prod_sel_r == sfb_pkg::MUL_TAP) begin
      fir_acc_r <= fir_sum;
    end
    if (prod_sel_r == sfb_pkg::MUL_DECAY) begin
      iir_acc_r <= IIR_W'(prod_r);
    end else if (prod_sel_r == sfb_pkg::MUL_INPUT) begin
      iir_acc_r <= iir_acc_r + (IIR_W'(prod_r) <<< 16);
    end
    if (prod_sel_r == sfb_pkg::MUL_MEAN) begin
      mean_r <= mean_nxt;
    end
    if (cmd.load_out) begin
      mean_out_r   <= mean_r;
      smooth_out_r <= smooth_val;
      fir_out_r    <= fir_sat;
    end
  end

  assign out_mean     = mean_out_r;
  assign out_smoothed = smooth_out_r;
  assign out_fir      = fir_out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sample_filter_bank.sv =====
// sample filter bank: mean of WINDOW_LEN samples, first-order iir and fir per word.
// the fir has min(5, WINDOW_LEN) taps. a new word is taken only once the last has
// been loaded into the result register. while a word is worked on, the single
// shared multiplier takes one product per cycle: iir decay, iir input, mean
// reciprocal, then one fir tap each cycle; the result register frees the input.
// synchronous active-low reset clears window, iir level and gains to defaults.
`default_nettype none

module sample_filter_bank #(
  parameter int WINDOW_LEN = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [sfb_pkg::SAMPLE_W-1:0]   in_tdata,   // [15:0] sample
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [sfb_pkg::OUT_W-1:0]           out_tdata,  // [15:0] mean_value,
                                                          // [31:16] smoothed_value,
                                                          // [47:32] fir_value
  input  wire logic                           cfg_wr_en,
  input  wire logic [sfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfb_pkg::GAIN_W-1:0]     cfg_wdata
);

  sfb_pkg::sfb_cmd_t                      cmd;
  logic signed [sfb_pkg::SAMPLE_W-1:0]    mean_v, smooth_v, fir_v;

  sfb_ctrl #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sfb_datapath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_sample    ($signed(in_tdata)),
    .cmd          (cmd),
    .out_mean     (mean_v),
    .out_smoothed (smooth_v),
    .out_fir      (fir_v)
  );

  assign out_tdata = {fir_v, smooth_v, mean_v};

endmodule

`default_nettype wire

// ===== hw/rtl/sfb_checker.sv =====
// port-level checks of the sample filter bank, bound to the top level
// depends on sample_filter_bank_defines.svh for the assertion macros
`default_nettype none

`include "sample_filter_bank_defines.svh"

module sfb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  // a stalled result stays offered and unchanged
  `SFB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `SFB_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))

  // one word in flight: input closes right after a take
  `SFB_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready)

  // leaving reset: no result offered and input open
  `SFB_ASSERT_NOW(a_reset_idle, $past(!rst_n), !out_tvalid && in_tready)

endmodule

bind sample_filter_bank sfb_checker u_sfb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
